// ----- hdl/imubc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package imubc_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int SUM_W      = 32;
  localparam int TARGET_W   = 16;
  localparam int CFG_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int BIAS_W     = 16;
  localparam int BIASZ_W    = 17;
  localparam int AXES       = 3;
  localparam int IN_USER_W  = 3;
  localparam int IN_DATA_W  = 2 * AXES * SAMPLE_W;
  localparam int OUT_FLAT_W = 5 * BIAS_W + BIASZ_W + 4;
  localparam int OUT_DATA_W = ((OUT_FLAT_W + 7) / 8) * 8;

  localparam logic [SUM_W-1:0]  POS_LIMIT = SUM_W'(32767);
  localparam logic [SUM_W-1:0]  NEG_LIMIT = SUM_W'(32768);
  localparam logic [BIAS_W-1:0] BIAS_MAX  = 16'h7fff;
  localparam logic [BIAS_W-1:0] BIAS_MIN  = 16'h8000;

  typedef enum logic [1:0] {
    FUNC_SAMPLE      = 2'd0,
    FUNC_START_GYRO  = 2'd1,
    FUNC_START_ACCEL = 2'd2,
    FUNC_CLEAR       = 2'd3
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GYRO_TARGET  = 2'd0,
    CFG_ACCEL_TARGET = 2'd1,
    CFG_EXPECTED_Z   = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV_G,
    ST_DIV_A,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic accept;
    logic load_div_g;
    logic load_div_a;
    logic store_g;
    logic store_a;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic gyro_fin;
    logic accel_fin;
    logic div_done;
  } status_t;

  // signed quotient from magnitude and sign, saturated to 16 bits
  function automatic logic [BIAS_W-1:0] sat_avg(input logic neg,
                                                input logic [SUM_W-1:0] q);
    logic [SUM_W-1:0] nq;
    nq = ~q + SUM_W'(1);
    if (!neg) begin
      return (q > POS_LIMIT) ? BIAS_MAX : q[BIAS_W-1:0];
    end
    return (q > NEG_LIMIT) ? BIAS_MIN : nq[BIAS_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ----- hdl/imubc_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
module imubc_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire imubc_pkg::func_t  func,
  input  wire logic              sample_valid,
  output logic                   out_valid,
  input  wire logic              out_ready,
  input  wire imubc_pkg::status_t status,
  output imubc_pkg::cmd_t        cmd
);

  imubc_pkg::state_t state, state_next;
  logic              out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= imubc_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    cmd            = '0;
    in_ready       = 1'b0;
    out_valid_next = out_valid && !out_ready;
    case (state)
      imubc_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (func == imubc_pkg::FUNC_SAMPLE && sample_valid) begin
            state_next = imubc_pkg::ST_CHECK;
          end else begin
            state_next = imubc_pkg::ST_OUT;
          end
        end
      end
      imubc_pkg::ST_CHECK: begin
        if (status.gyro_fin) begin
          cmd.load_div_g = 1'b1;
          state_next     = imubc_pkg::ST_DIV_G;
        end else if (status.accel_fin) begin
          cmd.load_div_a = 1'b1;
          state_next     = imubc_pkg::ST_DIV_A;
        end else begin
          state_next = imubc_pkg::ST_OUT;
        end
      end
      imubc_pkg::ST_DIV_G: begin
        if (status.div_done) begin
          cmd.store_g = 1'b1;
          if (status.accel_fin) begin
            cmd.load_div_a = 1'b1;
            state_next     = imubc_pkg::ST_DIV_A;
          end else begin
            state_next = imubc_pkg::ST_OUT;
          end
        end
      end
      imubc_pkg::ST_DIV_A: begin
        if (status.div_done) begin
          cmd.store_a = 1'b1;
          state_next  = imubc_pkg::ST_OUT;
        end
      end
      imubc_pkg::ST_OUT: begin
        if (!out_valid || out_ready) begin
          cmd.load_out   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = imubc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = imubc_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- hdl/imubc_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none
module imubc_dp #(
  parameter int COUNT_WIDTH = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire imubc_pkg::cmd_t                      cmd,
  output imubc_pkg::status_t                        status,
  input  wire logic                                 cfg_wr_en,
  input  wire logic [imubc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [imubc_pkg::CFG_W-1:0]          cfg_data,
  input  wire imubc_pkg::func_t                     func,
  input  wire logic                                 sample_valid,
  input  wire logic [imubc_pkg::IN_DATA_W-1:0]      in_data,
  output logic [imubc_pkg::OUT_DATA_W-1:0]          out_data
);

  localparam int SUM_W   = imubc_pkg::SUM_W;
  localparam int SMP_W   = imubc_pkg::SAMPLE_W;
  localparam int AXES    = imubc_pkg::AXES;
  localparam int CMP_W   = (COUNT_WIDTH > imubc_pkg::TARGET_W) ? COUNT_WIDTH
                                                               : imubc_pkg::TARGET_W;
  localparam int STEP_W  = $clog2(SUM_W);
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
  localparam logic [STEP_W-1:0]      LAST_STEP = STEP_W'(SUM_W - 1);

  logic [imubc_pkg::TARGET_W-1:0] gyro_target;
  logic [imubc_pkg::TARGET_W-1:0] accel_target;
  logic [imubc_pkg::CFG_W-1:0]    expected_z;

  logic [SUM_W-1:0]            gyro_sums  [AXES];
  logic [SUM_W-1:0]            accel_sums [AXES];
  logic [COUNT_WIDTH-1:0]      gyro_count, accel_count;
  logic                        gyro_active, accel_active;
  logic                        gyro_done, accel_done;
  logic [imubc_pkg::BIAS_W-1:0]  gyro_bias [AXES];
  logic [imubc_pkg::BIAS_W-1:0]  accel_bias_xy [2];
  logic [imubc_pkg::BIASZ_W-1:0] accel_bias_z;

  logic [COUNT_WIDTH-1:0]      divisor;
  logic [COUNT_WIDTH-1:0]      rem      [AXES];
  logic [SUM_W-1:0]            quo      [AXES];
  logic                        neg      [AXES];
  logic [COUNT_WIDTH:0]        rem_sh   [AXES];
  logic [COUNT_WIDTH-1:0]      rem_next [AXES];
  logic [SUM_W-1:0]            quo_next [AXES];
  logic [STEP_W-1:0]           step;
  logic                        busy, div_done;

  logic [SUM_W-1:0]            div_src  [AXES];
  logic [imubc_pkg::BIAS_W-1:0] avg     [AXES];
  logic [imubc_pkg::BIASZ_W-1:0] avg_z_adj;
  logic [COUNT_WIDTH-1:0]      gyro_count_next, accel_count_next;

  assign gyro_count_next  = (gyro_count  < COUNT_MAX) ? gyro_count  + 1'b1 : gyro_count;
  assign accel_count_next = (accel_count < COUNT_MAX) ? accel_count + 1'b1 : accel_count;

  assign status.gyro_fin  = gyro_active &&
    (CMP_W'(gyro_count) >= CMP_W'(gyro_target) || gyro_count == COUNT_MAX);
  assign status.accel_fin = accel_active &&
    (CMP_W'(accel_count) >= CMP_W'(accel_target) || accel_count == COUNT_MAX);
  assign status.div_done  = div_done;

  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      div_src[i] = cmd.load_div_g ? gyro_sums[i] : accel_sums[i];
      rem_sh[i]  = {rem[i], quo[i][SUM_W-1]};
      if (rem_sh[i] >= {1'b0, divisor}) begin
        rem_next[i] = COUNT_WIDTH'(rem_sh[i] - {1'b0, divisor});
        quo_next[i] = {quo[i][SUM_W-2:0], 1'b1};
      end else begin
        rem_next[i] = rem_sh[i][COUNT_WIDTH-1:0];
        quo_next[i] = {quo[i][SUM_W-2:0], 1'b0};
      end
      avg[i] = imubc_pkg::sat_avg(neg[i], quo[i]);
    end
    avg_z_adj = {avg[2][imubc_pkg::BIAS_W-1], avg[2]}
              - {expected_z[imubc_pkg::CFG_W-1], expected_z};
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      gyro_target  <= '0;
      accel_target <= '0;
      expected_z   <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        imubc_pkg::CFG_GYRO_TARGET:  gyro_target  <= cfg_data;
        imubc_pkg::CFG_ACCEL_TARGET: accel_target <= cfg_data;
        imubc_pkg::CFG_EXPECTED_Z:   expected_z   <= cfg_data;
        default: ;
      endcase
    end
  end

  // run state, sums and stored biases
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < AXES; i++) begin
        gyro_sums[i]  <= '0;
        accel_sums[i] <= '0;
        gyro_bias[i]  <= '0;
      end
      accel_bias_xy[0] <= '0;
      accel_bias_xy[1] <= '0;
      accel_bias_z     <= '0;
      gyro_count       <= '0;
      accel_count      <= '0;
      gyro_active      <= 1'b0;
      accel_active     <= 1'b0;
      gyro_done        <= 1'b0;
      accel_done       <= 1'b0;
    end else if (cmd.accept) begin
      case (func)
        imubc_pkg::FUNC_START_GYRO: begin
          for (int i = 0; i < AXES; i++) gyro_sums[i] <= '0;
          gyro_count  <= '0;
          gyro_active <= 1'b1;
          gyro_done   <= 1'b0;
        end
        imubc_pkg::FUNC_START_ACCEL: begin
          for (int i = 0; i < AXES; i++) accel_sums[i] <= '0;
          accel_count  <= '0;
          accel_active <= 1'b1;
          accel_done   <= 1'b0;
        end
        imubc_pkg::FUNC_CLEAR: begin
          for (int i = 0; i < AXES; i++) begin
            gyro_sums[i]  <= '0;
            accel_sums[i] <= '0;
            gyro_bias[i]  <= '0;
          end
          accel_bias_xy[0] <= '0;
          accel_bias_xy[1] <= '0;
          accel_bias_z     <= '0;
          gyro_count       <= '0;
          accel_count      <= '0;
          gyro_active      <= 1'b0;
          accel_active     <= 1'b0;
          gyro_done        <= 1'b0;
          accel_done       <= 1'b0;
        end
        imubc_pkg::FUNC_SAMPLE: begin
          if (sample_valid) begin
            if (gyro_active) begin
              for (int i = 0; i < AXES; i++) begin
                gyro_sums[i] <= gyro_sums[i] + SUM_W'($signed(in_data[SMP_W*i +: SMP_W]));
              end
              gyro_count <= gyro_count_next;
            end
            if (accel_active) begin
              for (int i = 0; i < AXES; i++) begin
                accel_sums[i] <= accel_sums[i]
                               + SUM_W'($signed(in_data[SMP_W*(AXES+i) +: SMP_W]));
              end
              accel_count <= accel_count_next;
            end
          end
        end
        default: ;
      endcase
    end else begin
      if (cmd.store_g) begin
        for (int i = 0; i < AXES; i++) gyro_bias[i] <= avg[i];
        gyro_done   <= 1'b1;
        gyro_active <= 1'b0;
      end
      if (cmd.store_a) begin
        accel_bias_xy[0] <= avg[0];
        accel_bias_xy[1] <= avg[1];
        accel_bias_z     <= avg_z_adj;
        accel_done       <= 1'b1;
        accel_active     <= 1'b0;
      end
    end
  end

  // three restoring divider lanes, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      div_done <= 1'b0;
      step     <= '0;
    end else if (cmd.load_div_g || cmd.load_div_a) begin
      busy     <= 1'b1;
      div_done <= 1'b0;
      step     <= '0;
    end else if (busy) begin
      step <= step + 1'b1;
      if (step == LAST_STEP) begin
        busy     <= 1'b0;
        div_done <= 1'b1;
      end
    end else begin
      div_done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_div_g || cmd.load_div_a) begin
      divisor <= cmd.load_div_g ? gyro_count : accel_count;
      for (int i = 0; i < AXES; i++) begin
        neg[i] <= div_src[i][SUM_W-1];
        quo[i] <= div_src[i][SUM_W-1] ? ~div_src[i] + SUM_W'(1) : div_src[i];
        rem[i] <= '0;
      end
    end else if (busy) begin
      for (int i = 0; i < AXES; i++) begin
        quo[i] <= quo_next[i];
        rem[i] <= rem_next[i];
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data <= imubc_pkg::OUT_DATA_W'({accel_active, gyro_active, accel_done, gyro_done,
                                          accel_bias_z, accel_bias_xy[1], accel_bias_xy[0],
                                          gyro_bias[2], gyro_bias[1], gyro_bias[0]});
    end
  end

endmodule
`default_nettype wire

// ----- hdl/imu_bias_calibrator_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Channel | Dir | Signals                   | Contents
// s_      | in  | tvalid tready tdata tuser | one request: command or IMU sample
// m_      | out | tvalid tready tdata       | biases and flags after the request
// cfg_    | in  | wr_en index data          | targets and expected accel Z
//
// A command or an unused sample goes from ST_IDLE straight to ST_OUT, where its result
// is registered; a counted sample that does not finish a run passes ST_CHECK first.
// A finishing run adds an ST_DIV_G or ST_DIV_A pass per sensor, gyro first,
// in the 32-step radix-2 divider with one lane per axis shared by both sensors.
// Reset is synchronous; the output register holds a result while m_tready is low,
// and a new request is taken while that result waits.
module imu_bias_calibrator_core #(
  parameter int COUNT_WIDTH = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 s_tvalid,
  output logic                                      s_tready,
  // gyro_x, gyro_y, gyro_z, accel_x, accel_y, accel_z
  input  wire logic [imubc_pkg::IN_DATA_W-1:0]      s_tdata,
  // func, sample_valid
  input  wire logic [imubc_pkg::IN_USER_W-1:0]      s_tuser,
  output logic                                      m_tvalid,
  input  wire logic                                 m_tready,
  // gyro_bias_x, gyro_bias_y, gyro_bias_z, accel_bias_x, accel_bias_y,
  // accel_bias_z, gyro_calibrated, accel_calibrated, gyro_running,
  // accel_running, zero pad
  output logic [imubc_pkg::OUT_DATA_W-1:0]          m_tdata,
  input  wire logic                                 cfg_wr_en,
  input  wire logic [imubc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [imubc_pkg::CFG_W-1:0]          cfg_data
);

  imubc_pkg::cmd_t    cmd;
  imubc_pkg::status_t status;
  imubc_pkg::func_t   func;
  logic               sample_valid;

  assign func         = imubc_pkg::func_t'(s_tuser[1:0]);
  assign sample_valid = s_tuser[2];

  imubc_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .func         (func),
    .sample_valid (sample_valid),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .status       (status),
    .cmd          (cmd)
  );

  imubc_dp #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .func         (func),
    .sample_valid (sample_valid),
    .in_data      (s_tdata),
    .out_data     (m_tdata)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request taken while previous one still in work");

  a_store_g_when_fin: assert property (@(posedge clk) disable iff (rst)
    cmd.store_g |-> status.gyro_fin && status.div_done)
    else $error("gyro bias stored without a finished run");

  a_store_a_when_fin: assert property (@(posedge clk) disable iff (rst)
    cmd.store_a |-> status.accel_fin && status.div_done)
    else $error("accel bias stored without a finished run");

  a_gyro_flags_excl: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[97] && m_tdata[99]))
    else $error("gyro calibrated and running together");

endmodule
`default_nettype wire
